// ===== src/svap_pkg.sv =====
// Shared types, constants and table functions for the sample voice player.
// No dependencies; svap_div and the top level import this package.
package svap_pkg;

    localparam int ADV_W      = 20;
    localparam int DIV_NW     = 32;
    localparam int ENV_W      = 12;
    localparam logic [ENV_W-1:0] ENV_FULL = 12'h888;
    localparam logic [ENV_W-1:0] ENV_HALF = 12'h444;
    localparam int SCALE_DIV  = 384;
    localparam int SINGLE_MAX = 256;
    localparam int PITCH_LIMIT = 108;

    localparam logic [2:0] CFG_ENVELOPE = 3'd0;
    localparam logic [2:0] CFG_LENGTH   = 3'd1;
    localparam logic [2:0] CFG_ADDRESS  = 3'd2;
    localparam logic [2:0] CFG_VOLUME   = 3'd3;
    localparam logic [2:0] CFG_PITCH    = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_PER, S_PER_W, S_PH, S_PH_W, S_WRAP, S_MOD, S_MOD_W, S_RD,
        S_ENV, S_ENV_W, S_SMP, S_LMUL, S_LDIV, S_RMUL, S_RDIV,
        S_UPD, S_VU, S_VU_W, S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    function automatic logic [ADV_W-1:0] semitone_step(input logic [3:0] s);
        logic [ADV_W-1:0] r;
        case (s)
            4'd0:    r = 20'h80000;
            4'd1:    r = 20'h879c8;
            4'd2:    r = 20'h8facd;
            4'd3:    r = 20'h9837f;
            4'd4:    r = 20'ha1451;
            4'd5:    r = 20'haadc1;
            4'd6:    r = 20'hb504f;
            4'd7:    r = 20'hbfc88;
            4'd8:    r = 20'hcb2ff;
            4'd9:    r = 20'hd7450;
            4'd10:   r = 20'he411f;
            4'd11:   r = 20'hf1a1c;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Phase advance for a note below the pitch limit: octave by reciprocal multiply.
    function automatic logic [ADV_W-1:0] note_advance(input logic [6:0] p);
        logic [12:0] m;
        logic [3:0]  oct;
        logic [6:0]  semi;
        m    = 13'(p) * 13'd43;
        oct  = m[12:9];
        semi = p - 7'(oct) * 7'd12;
        return semitone_step(semi[3:0]) >> (4'd8 - oct);
    endfunction

endpackage

// ===== src/svap_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on svap_pkg for the dividend width and the response struct.
module svap_div #(
    parameter int DVW = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [svap_pkg::DIV_NW-1:0] i_num,
    input  logic [DVW-1:0]              i_den,
    output svap_pkg::t_div_rsp          o_rsp,
    output logic [svap_pkg::DIV_NW-1:0] o_quo,
    output logic [DVW-1:0]              o_rem
);
    import svap_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_quo;
    logic [DVW-1:0]    r_rem, r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy, r_done;
    logic [DVW:0]      sh, diff;

    assign sh   = {r_rem, r_quo[DIV_NW-1]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[DVW]) begin
                r_rem <= diff[DVW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= sh[DVW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done};
    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

// ===== src/svap_store.sv =====
// Sample byte store: one write port, one registered read port.
// No package dependencies.
module svap_store #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sample_voice_adsr_player.sv =====
// Top level of the sample voice player: sequencer, voice state, result register.
// Depends on svap_pkg, svap_div and svap_store.
//
// Usage: write the five configuration registers through the cfg channel
// (always ready), then send commands on the in channel. Load writes one byte
// into the sample store; start copies the registers into a voice; render
// plays one frame of a voice into the mix sums; query only reports.
// Every command gives exactly one transfer on the out channel.
// Throughput: one item at a time; the next item is taken once the previous
// one reaches its result. Every variable division runs on one shared 32-step
// divider; the volume scaling by 384 uses a shift and a reciprocal multiply.
// Load, query and silent starts run at most one envelope division, for the
// VU report; a start runs up to two divisions; a render runs up to four.
// Reset clears all voice state and the configuration; the sample store is
// not cleared and holds nothing defined until written.
// A stalled receiver holds the result in its register; the block still takes
// the next item and parks it at its last step until the result is taken.
module sample_voice_adsr_player #(
    parameter int VOICES      = 4,
    parameter int SAMPLE_RATE = 44100,
    parameter int STORE_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_voice,
    input  logic [15:0] i_store_index,
    input  logic [7:0]  i_store_byte,
    input  logic signed [15:0] i_mix_left_in,
    input  logic signed [15:0] i_mix_right_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_mix_left_out,
    output logic signed [15:0] o_mix_right_out,
    output logic        o_voice_active,
    output logic        o_note_finished,
    output logic [7:0]  o_vu_level,
    output logic [15:0] o_play_position
);
    import svap_pkg::*;

    localparam int FRAME_PERIOD = SAMPLE_RATE * 16384 / 11025;
    localparam int PNUM   = FRAME_PERIOD * 337 / 2;
    localparam int PW     = $clog2(PNUM + 1);
    localparam int ENV_STEP = SAMPLE_RATE / 15;
    localparam int END_W  = $clog2(ENV_STEP * 60 + 1);
    localparam int DVW    = (PW > END_W) ? ((PW > 16) ? PW : 16) : ((END_W > 16) ? END_W : 16);
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;

    // voice state
    logic [PW-1:0]    r_cnt_a [VOICES];
    logic [ADV_W-1:0] r_adv_a [VOICES];
    logic [PW-1:0]    r_per_a [VOICES];
    logic [31:0]      r_age_a [VOICES];
    logic [END_W-1:0] r_ae_a [VOICES], r_de_a [VOICES], r_se_a [VOICES], r_re_a [VOICES];
    logic [15:0]      r_idx_a [VOICES], r_len_a [VOICES], r_base_a [VOICES];
    logic [7:0]       r_vol_a [VOICES];
    logic             r_loop_a [VOICES];

    // working copy of the addressed voice
    logic [PW-1:0]    r_cnt, r_per;
    logic [ADV_W-1:0] r_adv;
    logic [31:0]      r_age;
    logic [END_W-1:0] r_ae, r_de, r_se, r_re;
    logic [15:0]      r_idx, r_len, r_base;
    logic [7:0]       r_vol;
    logic             r_loop;

    logic [15:0] r_env_cfg, r_len_cfg, r_addr_cfg;
    logic [7:0]  r_vol_cfg, r_pitch_cfg;

    t_state r_state, n_state;
    logic [VW-1:0] r_vi;
    logic   r_ok, r_fin, r_over, r_pos_ok;
    logic [15:0] r_ml, r_mr;
    logic [ENV_W-1:0] r_env;
    logic signed [20:0] r_smp;
    logic signed [25:0] r_prod;
    logic [7:0]  r_vu;

    logic        r_ovalid, r_oact, r_ofin;
    logic [15:0] r_oml, r_omr, r_opos;
    logic [7:0]  r_ovu;

    logic in_xfer, ok_in, div_start;
    logic [VW-1:0] vi_in;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DVW-1:0] div_den, div_rem;
    t_div_rsp div_rsp;
    logic [7:0] st_rdata;
    logic [16:0] pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign vi_in       = VW'(i_voice);
    assign ok_in       = 32'(i_voice) < VOICES;
    assign pos         = 17'(r_base) + 17'(r_idx);

    // envelope segment at the current age
    logic [31:0] ea, ed, es, er, env_num;
    logic [DVW-1:0] env_den;
    logic env_direct, env_ov;
    logic [ENV_W-1:0] env_val;

    always_comb begin
        ea = 32'(r_ae);
        ed = 32'(r_de);
        es = 32'(r_se);
        er = 32'(r_re);
        env_num    = '0;
        env_den    = '0;
        env_direct = 1'b1;
        env_ov     = 1'b0;
        env_val    = '0;
        if (er == '0) begin
            env_val = ENV_FULL;
        end else if (r_age < ea) begin
            env_direct = 1'b0;
            env_num    = 32'(ENV_FULL) * r_age;
            env_den    = DVW'(r_ae);
        end else if (r_age < ed) begin
            env_direct = 1'b0;
            env_num    = 32'(ENV_HALF) * (2 * ed - ea - r_age);
            env_den    = DVW'(ed - ea);
        end else if (r_age < es) begin
            env_val = ENV_HALF;
        end else if (r_age < er) begin
            env_direct = 1'b0;
            env_num    = 32'(ENV_HALF) * (er - r_age);
            env_den    = DVW'(er - es);
        end else begin
            env_ov = 1'b1;
        end
    end

    function automatic logic [3:0] vu_side(input logic [ENV_W-1:0] e, input logic [3:0] v);
        logic [15:0] p;
        logic [4:0]  s;
        p = 16'(e) * 16'(v);
        s = 5'(p[15:11]) + 5'd1;
        if (v == '0) return 4'd0;
        return (s > 5'd15) ? 4'd15 : s[3:0];
    endfunction

    // Volume scaling: magnitude of the product divided by 384, truncated.
    // Drop the factor 128 by a shift, then divide by 3 with a reciprocal
    // multiply that is exact for every magnitude below 2^22.
    logic [21:0] mag;
    logic [31:0] scale_prod;
    logic [15:0] scale_q;
    assign mag        = r_prod[25] ? 22'(-r_prod) : 22'(r_prod);
    assign scale_prod = 32'(mag[21:7]) * 32'd43691;
    assign scale_q    = 16'(scale_prod[31:17]);

    // divider operands by step
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_PER: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(PNUM);
                div_den   = DVW'(r_len);
            end
            S_PH: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_cnt) + DIV_NW'(r_adv);
                div_den   = DVW'(r_per);
            end
            S_MOD: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_idx);
                div_den   = DVW'(r_len);
            end
            S_ENV, S_VU: begin
                div_start = !env_direct && r_ok && r_adv != '0 && r_per != '0;
                div_num   = env_num;
                div_den   = env_den;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_VU;
                    if (ok_in && i_command == CMD_RENDER && r_adv_a[vi_in] != '0
                        && r_per_a[vi_in] != '0) begin
                        n_state = S_PH;
                    end else if (ok_in && i_command == CMD_START && !silent
                                 && 32'(clamp_len) <= SINGLE_MAX) begin
                        n_state = S_PER;
                    end
                end
            end
            S_PER_W:  if (div_rsp.done) n_state = S_VU;
            S_PH:     n_state = S_PH_W;
            S_PH_W:   if (div_rsp.done) n_state = S_WRAP;
            S_WRAP: begin
                if (r_idx >= r_len) begin
                    n_state = (!r_loop || r_len == '0) ? S_VU : S_MOD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MOD:    n_state = S_MOD_W;
            S_MOD_W:  if (div_rsp.done) n_state = S_RD;
            S_RD:     n_state = S_ENV;
            S_ENV:    n_state = env_direct ? S_SMP : S_ENV_W;
            S_ENV_W:  if (div_rsp.done) n_state = S_SMP;
            S_SMP:    n_state = S_LMUL;
            S_LMUL:   n_state = S_LDIV;
            S_LDIV:   n_state = S_RMUL;
            S_RMUL:   n_state = S_RDIV;
            S_RDIV:   n_state = S_UPD;
            S_UPD:    n_state = S_VU;
            S_VU:     n_state = div_start ? S_VU_W : S_DONE;
            S_VU_W:   if (div_rsp.done) n_state = S_DONE;
            S_DONE:   if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            S_PER:    n_state = S_PER_W;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_cfg   <= '0;
            r_len_cfg   <= '0;
            r_addr_cfg  <= '0;
            r_vol_cfg   <= '0;
            r_pitch_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENVELOPE: r_env_cfg   <= i_cfg_data;
                CFG_LENGTH:   r_len_cfg   <= i_cfg_data;
                CFG_ADDRESS:  r_addr_cfg  <= i_cfg_data;
                CFG_VOLUME:   r_vol_cfg   <= i_cfg_data[7:0];
                CFG_PITCH:    r_pitch_cfg <= i_cfg_data[7:0];
                default:      r_env_cfg   <= r_env_cfg;
            endcase
        end
    end

    // start-time values from the configuration
    logic [16:0] limit;
    logic [15:0] clamp_len;
    logic [6:0]  pitch;
    logic        silent;
    always_comb begin
        limit     = (32'(r_addr_cfg) < STORE_DEPTH) ? 17'(STORE_DEPTH - 32'(r_addr_cfg)) : '0;
        clamp_len = (17'(r_len_cfg) > limit) ? limit[15:0] : r_len_cfg;
        pitch     = r_pitch_cfg[6:0];
        silent    = (32'(pitch) >= PITCH_LIMIT) || (clamp_len == '0);
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_vi   <= vi_in;
                    r_ok   <= ok_in;
                    r_fin  <= 1'b0;
                    r_ml   <= i_mix_left_in;
                    r_mr   <= i_mix_right_in;
                    r_cnt  <= r_cnt_a[vi_in];
                    r_adv  <= r_adv_a[vi_in];
                    r_per  <= r_per_a[vi_in];
                    r_age  <= r_age_a[vi_in];
                    r_ae   <= r_ae_a[vi_in];
                    r_de   <= r_de_a[vi_in];
                    r_se   <= r_se_a[vi_in];
                    r_re   <= r_re_a[vi_in];
                    r_idx  <= r_idx_a[vi_in];
                    r_len  <= r_len_a[vi_in];
                    r_base <= r_base_a[vi_in];
                    r_vol  <= r_vol_a[vi_in];
                    r_loop <= r_loop_a[vi_in];
                    if (ok_in && i_command == CMD_START) begin
                        r_len  <= clamp_len;
                        r_base <= r_addr_cfg;
                        r_vol  <= r_vol_cfg;
                        r_loop <= !r_pitch_cfg[7];
                        if (silent) begin
                            r_adv <= '0;
                        end else begin
                            r_adv <= note_advance(pitch);
                            r_ae  <= END_W'(ENV_STEP * 32'(r_env_cfg[15:12]));
                            r_de  <= END_W'(ENV_STEP * 32'(r_env_cfg[15:12])
                                     + ENV_STEP * 32'(r_env_cfg[11:8]));
                            r_se  <= END_W'(ENV_STEP * 32'(r_env_cfg[15:12])
                                     + ENV_STEP * 32'(r_env_cfg[11:8])
                                     + ENV_STEP * 32'(r_env_cfg[7:4]));
                            r_re  <= END_W'(ENV_STEP * 32'(r_env_cfg[15:12])
                                     + ENV_STEP * 32'(r_env_cfg[11:8])
                                     + ENV_STEP * 32'(r_env_cfg[7:4])
                                     + ENV_STEP * 32'(r_env_cfg[3:0]));
                            r_age <= '0;
                            r_idx <= '0;
                            r_per <= PW'(FRAME_PERIOD);
                        end
                    end
                end
            end
            S_PER_W: if (div_rsp.done) r_per <= div_quo[PW-1:0];
            S_PH_W: begin
                if (div_rsp.done) begin
                    r_idx <= r_idx + div_quo[15:0];
                    r_cnt <= div_rem[PW-1:0];
                end
            end
            S_WRAP: begin
                if (r_idx >= r_len && (!r_loop || r_len == '0)) begin
                    r_adv <= '0;
                    r_fin <= 1'b1;
                end
            end
            S_MOD_W:  if (div_rsp.done) r_idx <= div_rem[15:0];
            S_RD:     r_pos_ok <= 32'(pos) < STORE_DEPTH;
            S_ENV: begin
                r_env  <= env_val;
                r_over <= env_ov;
            end
            S_ENV_W:  if (div_rsp.done) r_env <= div_quo[ENV_W-1:0];
            S_SMP: begin
                r_smp <= (21'(signed'({1'b0, r_pos_ok ? st_rdata : 8'd0})) - 21'sd128)
                         * 21'(signed'({1'b0, r_env}));
            end
            S_LMUL:   r_prod <= 26'(r_smp) * 26'(signed'({1'b0, r_vol[7:4]}));
            S_LDIV:   r_ml <= r_prod[25] ? r_ml - scale_q : r_ml + scale_q;
            S_RMUL:   r_prod <= 26'(r_smp) * 26'(signed'({1'b0, r_vol[3:0]}));
            S_RDIV:   r_mr <= r_prod[25] ? r_mr - scale_q : r_mr + scale_q;
            S_UPD: begin
                r_age <= r_age + 1'b1;
                if (r_over) begin
                    r_adv <= '0;
                    r_fin <= 1'b1;
                end
            end
            S_VU: begin
                if (!r_ok || r_adv == '0 || r_per == '0) begin
                    r_vu <= '0;
                end else if (env_direct) begin
                    r_vu <= {vu_side(env_val, r_vol[7:4]), vu_side(env_val, r_vol[3:0])};
                end
            end
            S_VU_W: begin
                if (div_rsp.done) begin
                    r_vu <= {vu_side(div_quo[ENV_W-1:0], r_vol[7:4]),
                             vu_side(div_quo[ENV_W-1:0], r_vol[3:0])};
                end
            end
            default: begin
                r_vu <= r_vu;
            end
        endcase
    end

    // write back the voice and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_cnt_a[v]  <= '0;
                r_adv_a[v]  <= '0;
                r_per_a[v]  <= '0;
                r_age_a[v]  <= '0;
                r_ae_a[v]   <= '0;
                r_de_a[v]   <= '0;
                r_se_a[v]   <= '0;
                r_re_a[v]   <= '0;
                r_idx_a[v]  <= '0;
                r_len_a[v]  <= '0;
                r_base_a[v] <= '0;
                r_vol_a[v]  <= '0;
                r_loop_a[v] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
                if (r_ok) begin
                    r_cnt_a[r_vi]  <= r_cnt;
                    r_adv_a[r_vi]  <= r_adv;
                    r_per_a[r_vi]  <= r_per;
                    r_age_a[r_vi]  <= r_age;
                    r_ae_a[r_vi]   <= r_ae;
                    r_de_a[r_vi]   <= r_de;
                    r_se_a[r_vi]   <= r_se;
                    r_re_a[r_vi]   <= r_re;
                    r_idx_a[r_vi]  <= r_idx;
                    r_len_a[r_vi]  <= r_len;
                    r_base_a[r_vi] <= r_base;
                    r_vol_a[r_vi]  <= r_vol;
                    r_loop_a[r_vi] <= r_loop;
                end
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || i_out_ready)) begin
            r_oml  <= r_ml;
            r_omr  <= r_mr;
            r_oact <= r_ok && r_adv != '0 && r_per != '0;
            r_ofin <= r_fin;
            r_ovu  <= r_vu;
            r_opos <= r_ok ? r_idx : '0;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_mix_left_out  = r_oml;
    assign o_mix_right_out = r_omr;
    assign o_voice_active  = r_oact;
    assign o_note_finished = r_ofin;
    assign o_vu_level      = r_ovu;
    assign o_play_position = r_opos;

    svap_div #(.DVW(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    svap_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_command == CMD_LOAD && 32'(i_store_index) < STORE_DEPTH),
        .i_waddr (AW'(i_store_index)),
        .i_wdata (i_store_byte),
        .i_re    (r_state == S_RD),
        .i_raddr (AW'(pos)),
        .o_rdata (st_rdata)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_rsp.busy) else $error("divider started while busy");
    a_fin_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_note_finished) |-> !o_voice_active)
        else $error("finished note still active");

endmodule
